### hw/rtl/skset_pkg.sv
// Shared constants, operation codes and controller/datapath interface types for the key set.
package skset_pkg;

    // Default sizing, handed down through the top-level parameters
    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_KEY_WIDTH = 64;

    // Fixed field widths of the stream and register ports
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CNT_OUT_W = 9;
    localparam int MAXE_W    = 9;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Register map and reset value
    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic [MAXE_W-1:0] MAXE_RESET = 9'd256;

    // Operation codes carried on s_tuser
    localparam logic [S_TUSER_W-1:0] OP_ADD       = 3'd0;
    localparam logic [S_TUSER_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [S_TUSER_W-1:0] OP_MATCH_ALL = 3'd2;
    localparam logic [S_TUSER_W-1:0] OP_QUERY     = 3'd3;
    localparam logic [S_TUSER_W-1:0] OP_MARK      = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch the accepted request
        logic srch_init;   // open the search window over the whole table
        logic srch_probe;  // read the middle entry of the window
        logic srch_update; // narrow the window with the probed entry
        logic shu_init;    // point at the first free slot
        logic shu_rd;      // read the entry below the pointer
        logic shu_wr;      // move it up one slot, step down
        logic ins_write;   // write the new key at its slot
        logic shd_init;    // point at the matched entry
        logic shd_rd;      // read the entry above the pointer
        logic shd_wr;      // move it down one slot, step up
        logic del_done;    // drop the last slot, flag the removal
        logic enter_all;   // switch to match-all and empty the table
        logic mark_saved;  // clear the changed flag
        logic query_done;  // record the query hit and run state
        logic resp;        // load the output register
    } skset_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [S_TUSER_W-1:0] op;
        logic all_mode;
        logic room;
        logic srch_done;
        logic key_hit;
        logic ptr_at_pos;
        logic ptr_at_end;
        logic out_free;
    } skset_stat_t;

endpackage

### hw/rtl/sorted_key_set_with_overflow.sv
// Top level of the sorted key set with overflow to match-all mode.
//
//   channel   direction  handshake         contents
//   s_        in         s_tvalid/tready   tdata key, tuser opcode, tlast end of query run
//   m_        out        m_tvalid/tready   tdata status bits, tlast end of query run
//   APB       in/out     psel/penable      max_entries at byte address 0
//
// One request is in flight at a time. Each passes through accept, dispatch and
// response. A search adds a step to close the window, plus a read and an update
// for each binary-search probe over the key memory (at most ceil(log2(count+1))
// probes). An insert or a removal adds a final write or drop, after a read and a
// write for each entry moved.
// Reset clears the count and flags at once; the key memory needs no clearing pass.
// A result that is not taken holds in the output register; one further request is
// accepted and waits with its result until the register frees, and input stalls meanwhile.
module sorted_key_set_with_overflow
    import skset_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // key
    input  logic [S_TUSER_W-1:0] s_tuser,  // opcode
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // found, run_hit, match_all, entry_count[8:0], dirty
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [MAXE_W-1:0] max_entries_reg;
    logic              reg_sel;
    skset_cmd_t        cmd;
    skset_stat_t       stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1] == REG_MAX_ENTRIES);

    // Write the limit register on a completed access
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAXE_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            max_entries_reg <= pwdata[MAXE_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DW'(max_entries_reg) : '0;

    skset_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skset_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .max_entries (max_entries_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### hw/rtl/skset_ctrl.sv
// Sequencing state machine for the key set: dispatch, search, shift and response.
module skset_ctrl
    import skset_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  skset_stat_t stat,
    output skset_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DISPATCH  = 9'b000000010,
        ST_SRCH      = 9'b000000100,
        ST_SRCH_WAIT = 9'b000001000,
        ST_SHU_RD    = 9'b000010000,
        ST_SHU_WR    = 9'b000100000,
        ST_SHD_RD    = 9'b001000000,
        ST_SHD_WR    = 9'b010000000,
        ST_RESP      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Decide the next step and the datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_RESP;
                case (stat.op)
                    OP_ADD: begin
                        if (!stat.all_mode) begin
                            if (stat.room) begin
                                cmd.srch_init = 1'b1;
                                state_next    = ST_SRCH;
                            end else begin
                                cmd.enter_all = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (!stat.all_mode) begin
                            cmd.srch_init = 1'b1;
                            state_next    = ST_SRCH;
                        end
                    end
                    OP_MATCH_ALL: begin
                        cmd.enter_all = !stat.all_mode;
                    end
                    OP_QUERY: begin
                        if (stat.all_mode) begin
                            cmd.query_done = 1'b1;
                        end else begin
                            cmd.srch_init = 1'b1;
                            state_next    = ST_SRCH;
                        end
                    end
                    OP_MARK: begin
                        cmd.mark_saved = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SRCH: begin
                if (stat.srch_done) begin
                    state_next = ST_RESP;
                    case (stat.op)
                        OP_ADD: begin
                            cmd.shu_init = 1'b1;
                            state_next   = ST_SHU_RD;
                        end
                        OP_REMOVE: begin
                            if (stat.key_hit) begin
                                cmd.shd_init = 1'b1;
                                state_next   = ST_SHD_RD;
                            end
                        end
                        default: begin
                            cmd.query_done = 1'b1;
                        end
                    endcase
                end else begin
                    cmd.srch_probe = 1'b1;
                    state_next     = ST_SRCH_WAIT;
                end
            end
            ST_SRCH_WAIT: begin
                cmd.srch_update = 1'b1;
                state_next      = ST_SRCH;
            end
            ST_SHU_RD: begin
                if (stat.ptr_at_pos) begin
                    cmd.ins_write = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    cmd.shu_rd = 1'b1;
                    state_next = ST_SHU_WR;
                end
            end
            ST_SHU_WR: begin
                cmd.shu_wr = 1'b1;
                state_next = ST_SHU_RD;
            end
            ST_SHD_RD: begin
                if (stat.ptr_at_end) begin
                    cmd.del_done = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.shd_rd = 1'b1;
                    state_next = ST_SHD_WR;
                end
            end
            ST_SHD_WR: begin
                cmd.shd_wr = 1'b1;
                state_next = ST_SHD_RD;
            end
            ST_RESP: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    cmd.resp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/skset_dp.sv
// Datapath of the key set: sorted key memory, search window, shift pointer, flags, output register.
module skset_dp
    import skset_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    input  logic [MAXE_W-1:0]    max_entries,
    input  skset_cmd_t           cmd,
    output skset_stat_t          stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > MAXE_W) ? CW : MAXE_W;

    // Key memory
    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;

    // Request and working registers
    logic [S_TUSER_W-1:0] op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 last_reg;
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [CW-1:0]        mid_reg;
    logic                 hi_moved_reg;
    logic                 eq_reg;
    logic [CW-1:0]        ptr_reg;

    // Persistent state
    logic [CW-1:0]        count_reg;
    logic                 all_mode_reg;
    logic                 changed_reg;
    logic                 accum_reg;

    // Per-request result bits
    logic                 found_reg;
    logic                 run_hit_reg;
    logic                 run_end_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        ptr_dec;
    logic [CW-1:0]        ptr_inc;
    logic                 hit;
    logic                 accum_new;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign ptr_dec   = ptr_reg - CW'(1);
    assign ptr_inc   = ptr_reg + CW'(1);
    assign hit       = all_mode_reg | (hi_moved_reg & eq_reg);
    assign accum_new = accum_reg | hit;

    // Status towards the controller
    always_comb begin
        stat.op         = op_reg;
        stat.all_mode   = all_mode_reg;
        stat.room       = (count_reg != CW'(CAPACITY)) &&
                          (LW'(count_reg) < LW'(max_entries));
        stat.srch_done  = (lo_reg == hi_reg);
        stat.key_hit    = hi_moved_reg & eq_reg;
        stat.ptr_at_pos = (ptr_reg == lo_reg);
        stat.ptr_at_end = (ptr_inc == count_reg);
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // Select memory read and write addresses
    always_comb begin
        rd_en   = cmd.srch_probe | cmd.shu_rd | cmd.shd_rd;
        rd_addr = mid[AW-1:0];
        if (cmd.shu_rd) begin
            rd_addr = ptr_dec[AW-1:0];
        end else if (cmd.shd_rd) begin
            rd_addr = ptr_inc[AW-1:0];
        end
        wr_en   = cmd.shu_wr | cmd.shd_wr | cmd.ins_write;
        wr_addr = cmd.ins_write ? lo_reg[AW-1:0] : ptr_reg[AW-1:0];
        wr_data = cmd.ins_write ? key_reg : rd_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Latch the request, run the search window and shift pointer, record results, load output data
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_tuser;
            key_reg     <= s_tdata[KEY_WIDTH-1:0];
            last_reg    <= s_tlast;
            found_reg   <= 1'b0;
            run_hit_reg <= 1'b0;
            run_end_reg <= 1'b0;
        end
        if (cmd.srch_init) begin
            lo_reg       <= '0;
            hi_reg       <= count_reg;
            hi_moved_reg <= 1'b0;
            eq_reg       <= 1'b0;
        end
        if (cmd.srch_probe) begin
            mid_reg <= mid;
        end
        if (cmd.srch_update) begin
            if (rd_data_reg < key_reg) begin
                lo_reg <= mid_reg + CW'(1);
            end else begin
                hi_reg       <= mid_reg;
                hi_moved_reg <= 1'b1;
                eq_reg       <= (rd_data_reg == key_reg);
            end
        end
        if (cmd.shu_init) begin
            ptr_reg <= count_reg;
        end else if (cmd.shd_init) begin
            ptr_reg <= lo_reg;
        end else if (cmd.shu_wr) begin
            ptr_reg <= ptr_dec;
        end else if (cmd.shd_wr) begin
            ptr_reg <= ptr_inc;
        end
        if (cmd.del_done) begin
            found_reg <= 1'b1;
        end
        if (cmd.query_done) begin
            found_reg   <= hit;
            run_hit_reg <= accum_new;
            run_end_reg <= last_reg;
        end
        if (cmd.resp) begin
            m_data_reg <= M_TDATA_W'({changed_reg, CNT_OUT_W'(count_reg), all_mode_reg,
                                      run_hit_reg, found_reg});
            m_last_reg <= run_end_reg;
        end
    end

    // Update the set state and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            all_mode_reg <= 1'b0;
            changed_reg  <= 1'b0;
            accum_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.enter_all) begin
                all_mode_reg <= 1'b1;
                changed_reg  <= 1'b1;
                count_reg    <= '0;
            end else if (cmd.ins_write) begin
                count_reg   <= count_reg + CW'(1);
                changed_reg <= 1'b1;
            end else if (cmd.del_done) begin
                count_reg   <= count_reg - CW'(1);
                changed_reg <= 1'b1;
            end else if (cmd.mark_saved) begin
                changed_reg <= 1'b0;
            end
            if (cmd.query_done) begin
                accum_reg <= last_reg ? 1'b0 : accum_new;
            end
            if (cmd.resp) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### bench/key_set_checker.sv
// Checker for the sorted key set: predicts every status result and compares it with the block.
module key_set_checker
    import skset_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    input  logic [APB_DW-1:0]    prdata,
    input  logic                 pready,
    output int                   mismatch_count,
    output int                   pending_count,
    output int                   checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_AW-1:0] MAXE_ADDR = APB_AW'(4 * REG_MAX_ENTRIES);
    // Bit positions of the status fields in m_tdata
    localparam int CNT_LSB   = 3;
    localparam int DIRTY_BIT = CNT_LSB + CNT_OUT_W;
    localparam int PAD_LSB   = DIRTY_BIT + 1;

    typedef struct packed {
        logic                 found;
        logic                 run_hit;
        logic                 match_all;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 dirty;
        logic                 run_end;
    } key_status_t;

    // Own copy of the block's state
    logic [S_TDATA_W-1:0] sorted_keys[$];
    logic                 match_all_mode;
    logic                 changed;
    logic                 run_seen_hit;
    logic [MAXE_W-1:0]    max_keys;

    key_status_t status_due[$];
    int          n_bad;
    int          n_checked;

    function automatic void note_mismatch(input string msg);
        n_bad++;
        if (n_bad <= 10) begin
            $display("mismatch %0d: %s", n_bad, msg);
        end
    endfunction

    function automatic string status_text(input key_status_t s);
        return $sformatf("found %b run_hit %b match_all %b count %0d dirty %b run_end %b",
                         s.found, s.run_hit, s.match_all, s.entry_count, s.dirty, s.run_end);
    endfunction

    // Index of the first held key that is not below k
    function automatic int first_not_below(input logic [S_TDATA_W-1:0] k);
        int pos;
        pos = 0;
        while (pos < sorted_keys.size() && sorted_keys[pos] < k) begin
            pos++;
        end
        return pos;
    endfunction

    function automatic void enter_match_all();
        match_all_mode = 1'b1;
        changed        = 1'b1;
        sorted_keys.delete();
    endfunction

    // Apply one request to the state and return the status it produces
    function automatic key_status_t next_status(input logic [S_TUSER_W-1:0] op,
                                                input logic [S_TDATA_W-1:0] k,
                                                input logic                 last);
        key_status_t r;
        int          pos;
        int          limit;
        logic        present;
        r       = '0;
        limit   = (max_keys < DEF_CAPACITY) ? int'(max_keys) : DEF_CAPACITY;
        pos     = first_not_below(k);
        present = 1'b0;
        if (pos < sorted_keys.size()) begin
            present = (sorted_keys[pos] == k);
        end
        case (op)
            OP_ADD: begin
                if (!match_all_mode) begin
                    if (sorted_keys.size() < limit) begin
                        sorted_keys.insert(pos, k);
                        changed = 1'b1;
                    end else begin
                        enter_match_all();
                    end
                end
            end
            OP_REMOVE: begin
                if (!match_all_mode && present) begin
                    sorted_keys.delete(pos);
                    changed = 1'b1;
                    r.found = 1'b1;
                end
            end
            OP_MATCH_ALL: begin
                if (!match_all_mode) begin
                    enter_match_all();
                end
            end
            OP_QUERY: begin
                r.found      = match_all_mode || present;
                run_seen_hit = run_seen_hit || r.found;
                r.run_hit    = run_seen_hit;
                r.run_end    = last;
                if (last) begin
                    run_seen_hit = 1'b0;
                end
            end
            OP_MARK: begin
                changed = 1'b0;
            end
            default: begin
            end
        endcase
        r.match_all   = match_all_mode;
        r.entry_count = CNT_OUT_W'(sorted_keys.size());
        r.dirty       = changed;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        key_status_t got;
        key_status_t want;
        if (!aresetn) begin
            sorted_keys.delete();
            status_due.delete();
            match_all_mode = 1'b0;
            changed        = 1'b0;
            run_seen_hit   = 1'b0;
            max_keys       = MAXE_RESET;
        end else begin
            // Track register writes, check read-backs
            if (psel && penable && pready && paddr == MAXE_ADDR) begin
                if (pwrite) begin
                    max_keys = pwdata[MAXE_W-1:0];
                end else if (prdata[MAXE_W-1:0] !== max_keys) begin
                    note_mismatch($sformatf("max_entries read expected %0d, got %0d",
                                            max_keys, prdata[MAXE_W-1:0]));
                end
            end
            // Compare a result with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.found       = m_tdata[0];
                got.run_hit     = m_tdata[1];
                got.match_all   = m_tdata[2];
                got.entry_count = m_tdata[CNT_LSB +: CNT_OUT_W];
                got.dirty       = m_tdata[DIRTY_BIT];
                got.run_end     = m_tlast;
                if (status_due.size() == 0) begin
                    note_mismatch($sformatf("result with no request outstanding: %s",
                                            status_text(got)));
                end else begin
                    want = status_due.pop_front();
                    n_checked++;
                    if (got.found !== want.found || got.run_hit !== want.run_hit
                            || got.match_all !== want.match_all
                            || got.entry_count !== want.entry_count
                            || got.dirty !== want.dirty || got.run_end !== want.run_end
                            || m_tdata[M_TDATA_W-1:PAD_LSB] !== '0) begin
                        note_mismatch($sformatf("result %0d expected %s, got %s pad %h",
                                                n_checked, status_text(want), status_text(got),
                                                m_tdata[M_TDATA_W-1:PAD_LSB]));
                    end
                end
            end
            // Predict the status for an accepted request
            if (s_tvalid && s_tready) begin
                status_due.push_back(next_status(s_tuser, s_tdata, s_tlast));
            end
        end
        mismatch_count <= n_bad;
        pending_count  <= status_due.size();
        checked_count  <= n_checked;
    end

endmodule

### bench/tb_sorted_key_set_with_overflow.sv
// Testbench top for the sorted key set: clock, reset, request and register stimulus, verdict.
module tb_sorted_key_set_with_overflow
    import skset_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 110;
    localparam logic [APB_AW-1:0]    MAXE_ADDR  = APB_AW'(4 * REG_MAX_ENTRIES);
    localparam logic [S_TUSER_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [S_TUSER_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam logic [S_TDATA_W-1:0] KEY_ONES     = '1;
    localparam logic [S_TDATA_W-1:0] KEY_TOP      = {1'b1, {(S_TDATA_W-1){1'b0}}};

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int mismatch_count;
    int pending_count;
    int checked_count;

    // Stimulus-side mirror of the keys held, used to aim removes and queries and to bound adds and drains
    logic [S_TDATA_W-1:0] live_keys[$];
    int  cur_limit   = DEF_CAPACITY;
    int  peak_keys   = 0;
    int  n_sent      = 0;
    int  run_left    = 0;
    bit  overflowed  = 1'b0;
    bit  src_idle    = 1'b1;
    bit  sink_idle   = 1'b1;
    bit  hold_req    = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    sorted_key_set_with_overflow u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    key_set_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    // Stop a hung run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] fresh_key();
        case ($urandom_range(0, 3))
            0:       return S_TDATA_W'($urandom_range(0, 31));
            1:       return KEY_ONES - S_TDATA_W'($urandom_range(0, 31));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one request and hold it until accepted, with an optional gap first
    task automatic send_request(input logic [S_TUSER_W-1:0] op,
                                input logic [S_TDATA_W-1:0] key, input logic last);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    // Pause the source until every status has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write max_entries, then read it back
    task automatic write_limit(input logic [MAXE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAXE_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_limit = (value < DEF_CAPACITY) ? int'(value) : DEF_CAPACITY;
    endtask

    task automatic fill_to(input int n);
        logic [S_TDATA_W-1:0] key;
        while (live_keys.size() < n) begin
            key = fresh_key();
            live_keys.push_back(key);
            if (live_keys.size() > peak_keys) peak_keys = live_keys.size();
            send_request(OP_ADD, key, 1'($urandom_range(0, 1)));
        end
    endtask

    // Remove every held key in random order
    task automatic drain_keys();
        int idx;
        logic [S_TDATA_W-1:0] key;
        while (live_keys.size() != 0) begin
            idx = $urandom_range(0, live_keys.size() - 1);
            key = live_keys[idx];
            live_keys.delete(idx);
            send_request(OP_REMOVE, key, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_request();
        int pick;
        int share;
        logic [S_TUSER_W-1:0] op;
        logic [S_TDATA_W-1:0] key;
        logic last;
        pick = $urandom_range(0, 99);
        last = 1'($urandom_range(0, 1));
        key  = fresh_key();
        if (overflowed) op = S_TUSER_W'($urandom_range(OP_ADD, OP_UNUSED_HI));
        else if (pick < 35 && live_keys.size() < cur_limit) op = OP_ADD;
        else if (pick < 60) op = OP_REMOVE;
        else if (pick < 92) op = OP_QUERY;
        else if (pick < 96) op = OP_MARK;
        else op = S_TUSER_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        // Aim most removes and queries at held keys
        share = (op == OP_ADD) ? 20 : 65;
        if (live_keys.size() != 0 && $urandom_range(0, 99) < share) begin
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end
        if (!overflowed && op == OP_ADD) begin
            live_keys.push_back(key);
            if (live_keys.size() > peak_keys) peak_keys = live_keys.size();
        end else if (!overflowed && op == OP_REMOVE) begin
            for (int i = 0; i < live_keys.size(); i++) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end else if (op == OP_QUERY) begin
            if (run_left == 0) run_left = $urandom_range(1, 6);
            run_left--;
            last = (run_left == 0);
        end
        send_request(op, key, last);
    endtask

    initial begin : stimulus
        int    limits[5];
        int    way;
        string how;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, duplicates, runs, absent removes, spare codes
        send_request(OP_QUERY, '0, 1'b1);
        send_request(OP_ADD, '0, 1'b0);
        send_request(OP_ADD, KEY_ONES, 1'b1);
        send_request(OP_ADD, '0, 1'b0);
        send_request(OP_ADD, KEY_TOP, 1'b0);
        send_request(OP_ADD, S_TDATA_W'(1), 1'b0);
        send_request(OP_QUERY, KEY_ONES, 1'b0);
        send_request(OP_QUERY, S_TDATA_W'(2), 1'b0);
        send_request(OP_UNUSED_LO, KEY_TOP, 1'b1);
        send_request(OP_QUERY, S_TDATA_W'(3), 1'b1);
        send_request(OP_QUERY, S_TDATA_W'(3), 1'b1);
        send_request(OP_REMOVE, '0, 1'b0);
        send_request(OP_REMOVE, '0, 1'b1);
        send_request(OP_REMOVE, '0, 1'b0);
        send_request(OP_MARK, KEY_ONES, 1'b1);
        send_request(S_TUSER_W'(OP_UNUSED_LO + 1), '0, 1'b0);
        send_request(OP_UNUSED_HI, KEY_ONES, 1'b1);
        send_request(OP_REMOVE, KEY_ONES >> 1, 1'b0);
        send_request(OP_QUERY, KEY_TOP, 1'b1);
        send_request(OP_REMOVE, KEY_ONES, 1'b0);
        send_request(OP_REMOVE, KEY_TOP, 1'b1);
        send_request(OP_REMOVE, S_TDATA_W'(1), 1'b0);
        send_request(OP_MARK, '0, 1'b0);

        // Full capacity, with a long result hold-off while requests keep coming
        wait_drained();
        write_limit(MAXE_W'(DEF_CAPACITY));
        fill_to(DEF_CAPACITY);
        repeat (40) random_request();
        hold_req = 1'b1;
        repeat (100) random_request();
        drain_keys();

        // Zero limit on an empty table, no adds
        wait_drained();
        write_limit('0);
        repeat (40) random_request();

        limits = '{1, 3, 16, $urandom_range(2, 40), DEF_CAPACITY - 1};
        foreach (limits[i]) begin
            wait_drained();
            write_limit(MAXE_W'(limits[i]));
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) random_request();
            drain_keys();
        end

        // Enter match-all, by a way the seed picks
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        way = $urandom_range(0, 2);
        if (way == 0) begin
            how = "an add at the limit";
            wait_drained();
            write_limit(MAXE_W'(4));
            fill_to(4);
            send_request(OP_ADD, fresh_key(), 1'b0);
        end else if (way == 1) begin
            how = "the match-all request";
            fill_to(6);
            send_request(OP_MATCH_ALL, fresh_key(), 1'b1);
        end else begin
            how = "an add under a zero limit";
            fill_to(3);
            wait_drained();
            write_limit('0);
            send_request(OP_ADD, fresh_key(), 1'b1);
        end
        overflowed = 1'b1;
        live_keys.delete();
        repeat (100) random_request();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (150) random_request();

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests, checked %0d statuses; table peaked at %0d keys.",
                 n_sent, checked_count, peak_keys);
        $display("Limits 256, 0, 1, 3, 16, %0d, 255 used; match-all reached by %s.",
                 limits[3], how);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
